### rtl/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared widths, codes, reset values and item types for the Microwire
// EEPROM master.
// ----------------------------------------------------------------------------
package mwm_pkg;

	// field widths
	localparam int REQ_W      = 3;
	localparam int ADDR_W     = 8;
	localparam int DATA_W     = 16;
	localparam int STATUS_W   = 2;
	localparam int POLL_W     = 7;
	localparam int IVL_W      = 16;
	localparam int HALF_W     = 8;

	// apb port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// default geometry
	localparam int ADDR_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 16;

	// register reset values
	localparam logic [POLL_W-1:0] POLL_ATTEMPTS_RST = 7'd10;
	localparam logic [IVL_W-1:0]  POLL_IVL_RST      = 16'd1000;
	localparam logic [HALF_W-1:0] HALF_BIT_RST      = 8'd1;

	// register indexes
	localparam logic [1:0] REG_POLL_ATTEMPTS = 2'd0;
	localparam logic [1:0] REG_POLL_IVL      = 2'd1;
	localparam logic [1:0] REG_HALF_BIT      = 2'd2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_NONE  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_WRITE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ERASE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_EWEN  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_EWDS  = 3'd5;

	// microwire opcodes
	localparam logic [1:0] OP_EXT   = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_ERASE = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd2;

	typedef struct packed {
		logic [POLL_W-1:0] poll_attempts;
		logic [IVL_W-1:0]  poll_interval_ticks;
		logic [HALF_W-1:0] half_bit_ticks;
	} cfg_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [ADDR_W-1:0] word_address;
		logic [DATA_W-1:0] write_word;
		logic              data_out_pin;
	} req_item_t;

	typedef struct packed {
		logic                clock_pin;
		logic                select_pin;
		logic                data_in_pin;
		logic                busy_res;
		logic                done_res;
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   read_word;
	} res_item_t;

endpackage

### rtl/mwm_req_if.sv
// ----------------------------------------------------------------------------
// mwm_req_if
// Request channel: one item per serial timing tick.
// ----------------------------------------------------------------------------
interface mwm_req_if;
	logic                        valid;
	logic                        ready;
	logic [mwm_pkg::REQ_W-1:0]   req_type;
	logic [mwm_pkg::ADDR_W-1:0]  word_address;
	logic [mwm_pkg::DATA_W-1:0]  write_word;
	logic                        data_out_pin;

	modport source (output valid, req_type, word_address, write_word, data_out_pin,
		input ready);
	modport sink (input valid, req_type, word_address, write_word, data_out_pin,
		output ready);
endinterface

### rtl/mwm_rsp_if.sv
// ----------------------------------------------------------------------------
// mwm_rsp_if
// Result channel: pin levels and command status, one item per tick.
// ----------------------------------------------------------------------------
interface mwm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          clock_pin;
	logic                          select_pin;
	logic                          data_in_pin;
	logic                          busy_res;
	logic                          done_res;
	logic [mwm_pkg::STATUS_W-1:0]  status;
	logic [mwm_pkg::DATA_W-1:0]    read_word;

	modport source (output valid, clock_pin, select_pin, data_in_pin, busy_res, done_res,
		status, read_word, input ready);
	modport sink (input valid, clock_pin, select_pin, data_in_pin, busy_res, done_res,
		status, read_word, output ready);
endinterface

### rtl/mwm_apb_regs.sv
// ----------------------------------------------------------------------------
// mwm_apb_regs
// APB configuration registers: poll attempts, poll interval, half bit time.
// ----------------------------------------------------------------------------
module mwm_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mwm_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [mwm_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [mwm_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output mwm_pkg::cfg_t                    cfg
);
	import mwm_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_attempts       <= POLL_ATTEMPTS_RST;
			cfg_q.poll_interval_ticks <= POLL_IVL_RST;
			cfg_q.half_bit_ticks      <= HALF_BIT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_POLL_ATTEMPTS: cfg_q.poll_attempts       <= pwdata[POLL_W-1:0];
				REG_POLL_IVL:      cfg_q.poll_interval_ticks <= pwdata[IVL_W-1:0];
				REG_HALF_BIT:      cfg_q.half_bit_ticks      <= pwdata[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_POLL_ATTEMPTS: prdata = APB_DATA_W'(cfg_q.poll_attempts);
			REG_POLL_IVL:      prdata = APB_DATA_W'(cfg_q.poll_interval_ticks);
			REG_HALF_BIT:      prdata = APB_DATA_W'(cfg_q.half_bit_ticks);
			default:           prdata = '0;
		endcase
	end

endmodule

### rtl/mwm_core.sv
// ----------------------------------------------------------------------------
// mwm_core
// Microwire sequencer: one step per tick, frames a command, shifts it out,
// samples read data and polls for ready after write and erase.
// ----------------------------------------------------------------------------
module mwm_core #(
	parameter int ADDR_BITS = mwm_pkg::ADDR_BITS_DEF,
	parameter int WORD_BITS = mwm_pkg::WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  mwm_pkg::req_item_t item,
	input  mwm_pkg::cfg_t      cfg,
	output mwm_pkg::res_item_t result
);
	import mwm_pkg::*;

	localparam int SHIFT_W = 3 + ADDR_BITS + WORD_BITS;
	localparam int BL_W    = $clog2(SHIFT_W + 1);
	localparam int IDX_W   = $clog2(SHIFT_W);
	localparam int TICK_W  = IVL_W;

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_SEND_LOW  = 3'd1;
	localparam logic [2:0] PH_SEND_HIGH = 3'd2;
	localparam logic [2:0] PH_RECV_LOW  = 3'd3;
	localparam logic [2:0] PH_RECV_HIGH = 3'd4;
	localparam logic [2:0] PH_DESELECT  = 3'd5;
	localparam logic [2:0] PH_POLL      = 3'd6;
	localparam logic [2:0] PH_POLL_WAIT = 3'd7;

	localparam logic [BL_W-1:0] CMD_BITS  = BL_W'(3 + ADDR_BITS);
	localparam logic [BL_W-1:0] WR_BITS   = BL_W'(3 + ADDR_BITS + WORD_BITS);
	localparam logic [BL_W-1:0] RECV_BITS = BL_W'(WORD_BITS);

	// sequencer state
	logic [2:0]           phase_q, phase_d;
	logic [SHIFT_W-1:0]   shift_q, shift_d;
	logic [BL_W-1:0]      bits_q, bits_d;
	logic [TICK_W-1:0]    tick_q, tick_d;
	logic [POLL_W-1:0]    polls_q, polls_d;
	logic [WORD_BITS-1:0] rcv_q, rcv_d;
	logic [REQ_W-1:0]     pend_q;
	logic                 di_pin_q;

	// state after a possible command start
	logic [2:0]           ph;
	logic [SHIFT_W-1:0]   shf;
	logic [BL_W-1:0]      bl;
	logic [TICK_W-1:0]    tc;
	logic [WORD_BITS-1:0] rcv;
	logic [REQ_W-1:0]     pend;

	logic                 busy, is_req, start, finished, timeout;
	logic [1:0]           op;
	logic [ADDR_BITS-1:0] cmd_addr;
	logic [SHIFT_W-1:0]   load;
	logic [BL_W-1:0]      load_bits;
	logic [TICK_W:0]      tick_inc;
	logic [TICK_W:0]      half_lim, ivl_lim;
	logic [BL_W-1:0]      bl_m1, bl_dec;
	logic [POLL_W-1:0]    polls_dec;
	logic                 clk_d, sel_d, di_d;

	assign busy     = (phase_q != PH_IDLE);
	assign start    = !busy && is_req;
	assign half_lim = (cfg.half_bit_ticks == '0) ? (TICK_W+1)'(1)
		: (TICK_W+1)'(cfg.half_bit_ticks);
	assign ivl_lim  = (cfg.poll_interval_ticks == '0) ? (TICK_W+1)'(1)
		: (TICK_W+1)'(cfg.poll_interval_ticks);

	// request decode
	always_comb begin
		is_req    = 1'b1;
		op        = OP_EXT;
		cmd_addr  = ADDR_BITS'(item.word_address);
		unique case (item.req_type)
			REQ_READ:  op = OP_READ;
			REQ_WRITE: op = OP_WRITE;
			REQ_ERASE: op = OP_ERASE;
			REQ_EWEN:  cmd_addr = {2'b11, {(ADDR_BITS-2){1'b0}}};
			REQ_EWDS:  cmd_addr = '0;
			default:   is_req = 1'b0;
		endcase
		if (item.req_type == REQ_WRITE) begin
			load      = {1'b1, op, cmd_addr, WORD_BITS'(item.write_word)};
			load_bits = WR_BITS;
		end else begin
			load      = SHIFT_W'({1'b1, op, cmd_addr});
			load_bits = CMD_BITS;
		end
	end

	always_comb begin
		ph   = start ? PH_SEND_LOW : phase_q;
		shf  = start ? load : shift_q;
		bl   = start ? load_bits : bits_q;
		tc   = start ? '0 : tick_q;
		rcv  = (start && item.req_type == REQ_READ) ? '0 : rcv_q;
		pend = start ? item.req_type : pend_q;

		tick_inc  = (TICK_W+1)'(tc) + (TICK_W+1)'(1);
		bl_m1     = bl - BL_W'(1);
		bl_dec    = (bl != '0) ? bl_m1 : '0;
		polls_dec = (polls_q != '0) ? polls_q - POLL_W'(1) : '0;

		phase_d  = ph;
		shift_d  = shf;
		bits_d   = bl;
		tick_d   = tc;
		polls_d  = polls_q;
		rcv_d    = rcv;
		clk_d    = 1'b0;
		sel_d    = 1'b0;
		di_d     = di_pin_q;
		finished = 1'b0;
		timeout  = 1'b0;

		unique case (ph)
			PH_SEND_LOW: begin
				di_d  = shf[bl_m1[IDX_W-1:0]];
				sel_d = 1'b1;
				if (tick_inc >= half_lim) begin
					tick_d  = '0;
					phase_d = PH_SEND_HIGH;
				end else begin
					tick_d = tick_inc[TICK_W-1:0];
				end
			end
			PH_SEND_HIGH: begin
				clk_d  = 1'b1;
				sel_d  = 1'b1;
				bits_d = bl_dec;
				if (bl_dec != '0) begin
					phase_d = PH_SEND_LOW;
				end else if (pend == REQ_READ) begin
					bits_d  = RECV_BITS;
					phase_d = PH_RECV_LOW;
				end else begin
					phase_d = PH_DESELECT;
				end
			end
			PH_RECV_LOW: begin
				sel_d = 1'b1;
				if (tick_inc >= half_lim) begin
					tick_d  = '0;
					phase_d = PH_RECV_HIGH;
				end else begin
					tick_d = tick_inc[TICK_W-1:0];
				end
			end
			PH_RECV_HIGH: begin
				clk_d   = 1'b1;
				sel_d   = 1'b1;
				rcv_d   = {rcv[WORD_BITS-2:0], item.data_out_pin};
				bits_d  = bl_dec;
				phase_d = (bl_dec != '0) ? PH_RECV_LOW : PH_DESELECT;
			end
			PH_DESELECT: begin
				if (pend == REQ_WRITE || pend == REQ_ERASE) begin
					polls_d = (cfg.poll_attempts == '0) ? POLL_W'(1) : cfg.poll_attempts;
					phase_d = PH_POLL;
				end else begin
					finished = 1'b1;
					phase_d  = PH_IDLE;
				end
			end
			PH_POLL: begin
				sel_d = 1'b1;
				if (item.data_out_pin) begin
					finished = 1'b1;
					phase_d  = PH_IDLE;
				end else begin
					polls_d = polls_dec;
					if (polls_dec == '0) begin
						finished = 1'b1;
						timeout  = 1'b1;
						phase_d  = PH_IDLE;
					end else begin
						tick_d  = '0;
						phase_d = PH_POLL_WAIT;
					end
				end
			end
			PH_POLL_WAIT: begin
				sel_d = 1'b1;
				if (tick_inc >= ivl_lim) begin
					tick_d  = '0;
					phase_d = PH_POLL;
				end else begin
					tick_d = tick_inc[TICK_W-1:0];
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		result.clock_pin   = clk_d;
		result.select_pin  = sel_d;
		result.data_in_pin = di_d;
		result.busy_res    = (phase_d != PH_IDLE);
		result.done_res    = finished || (busy && is_req);
		result.read_word   = DATA_W'(rcv_d);
		if (finished) begin
			result.status = timeout ? ST_TIMEOUT : ST_OK;
		end else if (busy && is_req) begin
			result.status = ST_REJECT;
		end else begin
			result.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			shift_q   <= '0;
			bits_q    <= '0;
			tick_q    <= '0;
			polls_q   <= '0;
			rcv_q     <= '0;
			pend_q    <= REQ_NONE;
			di_pin_q  <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			shift_q   <= shift_d;
			bits_q    <= bits_d;
			tick_q    <= tick_d;
			polls_q   <= polls_d;
			rcv_q     <= rcv_d;
			pend_q    <= pend;
			di_pin_q  <= di_d;
		end
	end

endmodule

### rtl/microwire_eeprom_master.sv
// ----------------------------------------------------------------------------
// microwire_eeprom_master
// Microwire master for a x16 serial EEPROM, stepped once per tick item.
//
//   channel   role     payload
//   req       sink     req_type, word_address, write_word, data_out_pin
//   rsp       source   pin levels, busy_res, done_res, status, read_word
//   apb       slave    poll_attempts, poll_interval_ticks, half_bit_ticks
//
// one item per cycle sustained while rsp is not stalled; every item gives
// one result, loaded into the result register from the input register
// the sequencer step between the two registers sets the cycle time
// reset clears the sequencer to idle with all pins low, registers to defaults
// a stalled result holds the pipe; req stays ready while the input stage
// can move on
// ----------------------------------------------------------------------------
module microwire_eeprom_master #(
	parameter int ADDR_BITS = mwm_pkg::ADDR_BITS_DEF,
	parameter int WORD_BITS = mwm_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mwm_req_if.sink                          req,
	mwm_rsp_if.source                        rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mwm_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [mwm_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [mwm_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import mwm_pkg::*;

	cfg_t      cfg;
	req_item_t item_s1;
	logic      valid_s1;
	res_item_t res_d, res_q;
	logic      out_valid_q;
	logic      adv;

	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	mwm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mwm_core #(
		.ADDR_BITS (ADDR_BITS),
		.WORD_BITS (WORD_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type     <= req.req_type;
			item_s1.word_address <= req.word_address;
			item_s1.write_word   <= req.write_word;
			item_s1.data_out_pin <= req.data_out_pin;
		end
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.clock_pin   = res_q.clock_pin;
	assign rsp.select_pin  = res_q.select_pin;
	assign rsp.data_in_pin = res_q.data_in_pin;
	assign rsp.busy_res    = res_q.busy_res;
	assign rsp.done_res    = res_q.done_res;
	assign rsp.status      = res_q.status;
	assign rsp.read_word   = res_q.read_word;

	a_clk_needs_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.clock_pin |-> res_q.select_pin)
		else $error("serial clock high without chip select");

	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status != ST_OK |-> res_q.done_res)
		else $error("nonzero status without done");

	a_timeout_ends_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status == ST_TIMEOUT |-> res_q.select_pin && !res_q.busy_res)
		else $error("poll timeout not reported at end of poll");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("stepped item produced no result");

endmodule
